[sv/ssil_pkg.sv]
package ssil_pkg;

  // store capacity and derived widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OUT_CNT_W = 7;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // inverting the sign bit makes unsigned order match signed order
  localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

  // input transaction
  typedef struct packed {
    logic                    opcode;
    logic signed [VAL_W-1:0] value;
  } in_t;

  // result transaction
  typedef struct packed {
    logic                 found;
    logic                 inserted;
    logic                 full_res;
    logic [OUT_CNT_W-1:0] count;
  } out_t;

  // classified command from front to back
  typedef struct packed {
    logic             is_insert;
    logic [VAL_W-1:0] key;
  } cmd_t;

  // compare outcome of the cell row
  typedef struct packed {
    logic [CAPACITY-1:0] lt;
    logic                hit;
  } cmp_res_t;

endpackage

[sv/ssil_front.sv]
module ssil_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ssil_pkg::in_t item,
  output logic          full,
  output logic          cmd_valid,
  output ssil_pkg::cmd_t cmd,
  input  logic          cmd_take
);
  import ssil_pkg::*;

  localparam int QD = 2;

  cmd_t       queue [QD];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [1:0] fill_next;
  logic       push_ok;
  cmd_t       cls;

  // classify the incoming transaction
  always_comb begin
    cls.is_insert = (item.opcode == OP_INSERT);
    cls.key       = item.value ^ SIGN_FLIP;
  end

  assign full      = (fill == 2'(QD));
  assign push_ok   = push && !full;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = queue[rd_ptr];

  // fill count update
  always_comb begin
    unique case ({push_ok, cmd_take})
      2'b10:   fill_next = fill + 2'd1;
      2'b01:   fill_next = fill - 2'd1;
      default: fill_next = fill;
    endcase
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      queue[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'(QD))
    else $error("front queue overfilled");
  a_take_valid: assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
      (fill == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with fill");
`endif

endmodule

[sv/ssil_cells.sv]
module ssil_cells (
  input  logic                          clk,
  input  logic [ssil_pkg::CNT_W-1:0]    count,
  input  logic [ssil_pkg::VAL_W-1:0]    cmp_key,
  output ssil_pkg::cmp_res_t            cmp,
  input  logic                          wr_en,
  input  logic [ssil_pkg::VAL_W-1:0]    wr_key,
  input  logic [ssil_pkg::CAPACITY-1:0] wr_lt
);
  import ssil_pkg::*;

  logic [VAL_W-1:0]    entry [CAPACITY];
  logic [CAPACITY-1:0] eq;

  // parallel compare of every held entry against the key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmp.lt[i] = (CNT_W'(i) < count) && (entry[i] < cmp_key);
      eq[i]     = (CNT_W'(i) < count) && (entry[i] == cmp_key);
    end
    cmp.hit = |eq;
  end

  // each cell keeps, takes the key, or takes its lower neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (wr_en && !wr_lt[g]) begin
          entry[g] <= wr_key;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (wr_en && !wr_lt[g]) begin
          entry[g] <= wr_lt[g-1] ? wr_key : entry[g-1];
        end
      end
    end
  end

endmodule

[sv/ssil_back.sv]
module ssil_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  ssil_pkg::cmd_t  cmd,
  output logic            cmd_take,
  output logic            empty,
  input  logic            pop,
  output ssil_pkg::out_t  result
);
  import ssil_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state;
  logic             op_ins;
  logic [VAL_W-1:0] key_q;
  cmp_res_t         cmp;
  cmp_res_t         cmp_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_valid;
  logic             is_full;
  logic             do_ins;
  logic             pop_ok;

  ssil_cells u_cells (
    .clk     (clk),
    .count   (count),
    .cmp_key (cmd.key),
    .cmp     (cmp),
    .wr_en   (do_ins),
    .wr_key  (key_q),
    .wr_lt   (cmp_q.lt)
  );

  // take a command only when the result slot will be free
  assign pop_ok   = pop && out_valid;
  assign cmd_take = (state == ST_IDLE) && cmd_valid && (!out_valid || pop);
  assign empty    = !out_valid;

  // execute step decisions
  assign is_full    = (count == CNT_W'(CAPACITY));
  assign do_ins     = (state == ST_EXEC) && op_ins && !cmp_q.hit && !is_full;
  assign count_next = count + CNT_W'(do_ins);

  // latch command and compare outcome
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      op_ins <= cmd.is_insert;
      key_q  <= cmd.key;
      cmp_q  <= cmp;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      result.found    <= cmp_q.hit;
      result.inserted <= do_ins;
      result.full_res <= op_ins && !cmp_q.hit && is_full;
      result.count    <= OUT_CNT_W'(count_next);
    end
  end

  // sequencer, count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            state <= ST_EXEC;
          end
          if (pop_ok) begin
            out_valid <= 1'b0;
          end
        end
        ST_EXEC: begin
          state     <= ST_IDLE;
          count     <= count_next;
          out_valid <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
      (state == ST_EXEC) |-> !out_valid)
    else $error("result slot busy during execute");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
      (state == ST_EXEC) |=> out_valid)
    else $error("execute produced no result");
  a_sorted_row: assert property (@(posedge clk) disable iff (rst)
      (state == ST_EXEC) |-> ((cmp_q.lt & (cmp_q.lt + 1'b1)) == '0))
    else $error("compare vector not a thermometer, row unsorted");
`endif

endmodule

[sv/sorted_set_insert_lookup.sv]
// Sorted set of distinct signed 32-bit values, up to CAPACITY (64) entries held in
// ascending order in a row of registers. Push an insert or lookup transaction; each
// one gives exactly one result transaction with found, inserted, full_res and the
// entry count after it. A front queue of two classifies and buffers transactions; the
// back end handles each transaction as a compare step, which compares the key against
// every held entry at once as the command is taken, then a shift step, which shifts the
// larger entries up and loads the result register. The back end takes no new
// transaction until the current one is through, nor while an unpopped result holds
// the result register. From idle, a pushed transaction passes the front queue, the
// latched compare outcome and the result register before its result is on the ports.
// No clearing pass is needed after reset: cells above the count are never looked at.
module sorted_set_insert_lookup (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ssil_pkg::in_t  item,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output ssil_pkg::out_t result
);
  import ssil_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  ssil_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  ssil_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

[bench/sorted_set_checker.sv]
`timescale 1ns / 1ps

module sorted_set_checker
  import ssil_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  in_t  item,
  input  logic empty,
  input  logic pop,
  input  out_t result,
  output int   mismatches,
  output int   outstanding
);

  // mirror of the set, kept sorted ascending as signed values
  logic signed [VAL_W-1:0] held_set[$];
  // results owed by the block, oldest first
  out_t owed_results[$];
  int err_total = 0;

  // apply one command to the mirror and return the result it should give
  function automatic out_t apply_to_held_set(in_t cmd);
    int pos;
    out_t res;
    logic signed [VAL_W-1:0] key;
    key = cmd.value;
    res = '0;
    pos = 0;
    while (pos < held_set.size() && held_set[pos] < key) pos++;
    res.found = (pos < held_set.size() && held_set[pos] == key);
    if (cmd.opcode == OP_INSERT && !res.found) begin
      if (held_set.size() >= CAPACITY) begin
        res.full_res = 1'b1;
      end else begin
        held_set.insert(pos, key);
        res.inserted = 1'b1;
      end
    end
    // count wraps to the width of the port
    res.count = OUT_CNT_W'(held_set.size());
    return res;
  endfunction

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: field %s expected %0d, got %0d", $time, name, want, got);
      err_total++;
    end
  endtask

  // watch both channels; results are compared before new commands are queued
  always @(posedge clk) begin : watch
    out_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with nothing owed, expected none, got %p", $time, result);
          err_total++;
        end else begin
          want = owed_results.pop_front();
          check_field("found", want.found, result.found);
          check_field("inserted", want.inserted, result.inserted);
          check_field("full_res", want.full_res, result.full_res);
          check_field("count", want.count, result.count);
        end
      end
      if (push && !full) begin
        owed_results.push_back(apply_to_held_set(item));
      end
    end
    mismatches  <= err_total;
    outstanding <= owed_results.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ssil_pkg::*;

  localparam int RANDOM_ITEMS = 1380;
  localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic push = 1'b0;
  logic pop  = 1'b0;
  in_t  item = '0;
  logic full;
  logic empty;
  out_t result;
  int   mismatches;
  int   outstanding;

  // values sent as inserts, reused for duplicates, lookups and neighbors
  logic signed [VAL_W-1:0] insert_history[$];
  int results_taken = 0;

  always #4 clk = ~clk;

  sorted_set_insert_lookup uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  sorted_set_checker chk (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // idle length: mostly none, some short, a few long
  function automatic int idle_gap(bit steady);
    int r;
    r = $urandom_range(99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // value mix: reuse and neighbors of earlier inserts, fresh random, small, extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    logic signed [VAL_W-1:0] v;
    r = $urandom_range(99);
    if (insert_history.size() > 0 && r < 75) begin
      v = insert_history[$urandom_range(insert_history.size() - 1)];
      if (r < 10) v = v + 1;
      else if (r < 20) v = v - 1;
    end else if (r < 85) begin
      v = $urandom;
    end else if (r < 95) begin
      v = $signed($urandom_range(32)) - 16;
    end else begin
      v = $urandom_range(1) ? MOST_POS : MOST_NEG;
    end
    return v;
  endfunction

  // offer one transaction after an optional gap and wait until it is taken
  task automatic offer(logic op, logic signed [VAL_W-1:0] val, int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= '{opcode: op, value: val};
    push <= 1'b1;
    do @(posedge clk); while (full);
    if (op == OP_INSERT) insert_history.push_back(val);
  endtask

  // sender
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty set, extremes, duplicates, neighbors, bit patterns
    offer(OP_LOOKUP, 0, 0);
    offer(OP_INSERT, 0, 0);
    offer(OP_INSERT, 0, idle_gap(1'b0));
    offer(OP_INSERT, MOST_NEG, 0);
    offer(OP_INSERT, MOST_POS, idle_gap(1'b0));
    offer(OP_LOOKUP, MOST_NEG, 0);
    offer(OP_LOOKUP, MOST_POS, 0);
    offer(OP_INSERT, -1, idle_gap(1'b0));
    offer(OP_INSERT, 1, 0);
    offer(OP_LOOKUP, -1, 0);
    offer(OP_LOOKUP, 2, idle_gap(1'b0));
    offer(OP_INSERT, MOST_POS - 1, 0);
    offer(OP_INSERT, MOST_NEG + 1, 0);
    offer(OP_LOOKUP, MOST_NEG + 1, idle_gap(1'b0));
    offer(OP_LOOKUP, 32'shAAAAAAAA, 0);
    offer(OP_LOOKUP, 32'sh55555555, 0);
    offer(OP_INSERT, 32'sh55555555, idle_gap(1'b0));
    offer(OP_INSERT, 32'shAAAAAAAA, 0);
    offer(OP_LOOKUP, 32'shAAAAAAAA, 0);
    offer(OP_INSERT, 100, 0);
    offer(OP_INSERT, -100, idle_gap(1'b0));
    offer(OP_INSERT, 50, 0);
    offer(OP_INSERT, MOST_NEG, 0);

    // random: set fills slowly, then full-store rejects and duplicates
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      offer(($urandom_range(99) < 45) ? OP_LOOKUP : OP_INSERT, pick_value(),
            idle_gap((n / 100) % 3 == 0));
    end
    push <= 1'b0;

    // drain, then allow for the pipeline latency
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sorted_set_insert_lookup: match");
    end else begin
      $display("sorted_set_insert_lookup: mismatch");
    end
    $finish;
  end

  // receiver, with one long hold-off so the block backs up and asserts full
  initial begin : drain
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (results_taken == 300) begin
        pop <= 1'b0;
        repeat (250) @(posedge clk);
      end else begin
        gap = idle_gap((results_taken / 150) % 3 == 1);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      results_taken++;
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("sorted_set_insert_lookup: mismatch");
    $finish;
  end

endmodule
